@@ sv/cycloid_swing_foot_trajectory_assert.svh @@
// Assertion macros for the cycloid swing foot trajectory block.
// Needs nothing; each macro takes its clock and active-low reset as arguments.
`ifndef CYCLOID_SWING_FOOT_TRAJECTORY_ASSERT_SVH
`define CYCLOID_SWING_FOOT_TRAJECTORY_ASSERT_SVH

// same-cycle implication
`define CSFT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/csft_pkg.sv @@
// Package for the cycloid swing foot trajectory block: widths, fixed-point
// constants, register indexes, quarter-wave sine table and rounding helpers.
// Depends on nothing.
`timescale 1ns / 1ps

package csft_pkg;

	localparam int NUM_FEET         = 2;
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int IDX_W            = $clog2(4 * SINE_TABLE_DEPTH);
	localparam int R_W              = $clog2(SINE_TABLE_DEPTH);
	localparam int ROM_W            = 17;
	localparam int POS_W            = 20;
	localparam int TAYLOR_TERMS     = 8;

	localparam int S_DATA_W   = 120;
	localparam int S_USER_W   = 3;
	localparam int M_DATA_W   = 120;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_GAIT_HEIGHT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SWING_TIME = 1'd1;

	localparam logic [15:0] GAIT_HEIGHT_RST    = 16'd5243;
	localparam logic [23:0] INV_SWING_TIME_RST = 24'd163840;

	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam int          INV_TWO_PI_Q32 = 683565276;
	localparam int          PI_Q16         = 205887;
	localparam int          ONE_Q16        = 65536;

	localparam logic signed [63:0] POS_MAX = 64'sd524287;
	localparam logic signed [63:0] POS_MIN = -64'sd524288;

	typedef logic [ROM_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	// sin(pi/2 * k / depth) in Q16 from a Q30 Taylor series
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if ((n & 1) != 0) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 64'sd8192) >>> 14;
			if (sum > 65536) begin
				sum = 65536;
			end
			rom[k] = ROM_W'(sum);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// round to nearest, halves away from zero
	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
			input logic [5:0] sh);
		logic [63:0] mag;
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (sh - 6'd1))) >> sh;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [POS_W-1:0] sat20(input logic signed [63:0] v);
		logic signed [POS_W-1:0] r;
		if (v > POS_MAX) begin
			r = POS_W'(POS_MAX);
		end else if (v < POS_MIN) begin
			r = POS_W'(POS_MIN);
		end else begin
			r = POS_W'(v);
		end
		return r;
	endfunction

endpackage

@@ sv/cycloid_swing_foot_trajectory.sv @@
// Swing foot trajectory generator: cycloid XY, raised-cosine Z, scaled velocities.
// Uses csft_pkg and the assertion macros in cycloid_swing_foot_trajectory_assert.svh.
// Sequence: a stance word goes from accept to ST_DONE; a swing word passes ST_TRIG, ST_MUL and ST_DONE.
// ST_DONE holds until the output register is free; s_tready is high only in ST_IDLE, so each word finishes
// before the next is accepted. A swing word issues 14 products one per cycle through one shared multiplier.
// Reset: asynchronous active-low arst_n clears both start-valid flags, the
// sequencer and output valid, and loads the register reset values.
`timescale 1ns / 1ps
`include "cycloid_swing_foot_trajectory_assert.svh"

module cycloid_swing_foot_trajectory (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [csft_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csft_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// phase, meas_x, meas_y, meas_z, target_x, target_y, 4 zero bits
	input  logic [csft_pkg::S_DATA_W-1:0]      s_tdata,
	// foot, contact, resync
	input  logic [csft_pkg::S_USER_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	output logic [csft_pkg::M_DATA_W-1:0]      m_tdata
);
	import csft_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TRIG = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [3:0] OP_SK     = 4'd0;
	localparam logic [3:0] OP_HS     = 4'd1;
	localparam logic [3:0] OP_HZ     = 4'd2;
	localparam logic [3:0] OP_MX     = 4'd3;
	localparam logic [3:0] OP_MY     = 4'd4;
	localparam logic [3:0] OP_PX     = 4'd5;
	localparam logic [3:0] OP_PY     = 4'd6;
	localparam logic [3:0] OP_NZ     = 4'd7;
	localparam logic [3:0] OP_VX_HI  = 4'd8;
	localparam logic [3:0] OP_VX_LO  = 4'd9;
	localparam logic [3:0] OP_VY_HI  = 4'd10;
	localparam logic [3:0] OP_VY_LO  = 4'd11;
	localparam logic [3:0] OP_VZ_HI  = 4'd12;
	localparam logic [3:0] OP_VZ_LO  = 4'd13;
	localparam logic [3:0] STEP_LAST = 4'd14;

	logic [1:0]  state_q;
	logic [3:0]  step_q;
	logic [NUM_FEET-1:0] valid_q;
	logic        m_tvalid_q;
	logic [15:0] gait_height_q;
	logic [23:0] inv_swing_time_q;

	logic signed [POS_W-1:0] start_q [NUM_FEET][3];

	logic        foot_q;
	logic [15:0] phase_q;
	logic signed [POS_W-1:0] tgt_x_q;
	logic signed [POS_W-1:0] tgt_y_q;
	logic signed [17:0] s_q;
	logic [17:0] omc_q;
	logic signed [20:0] dx_q;
	logic signed [20:0] dy_q;
	logic signed [17:0] f_q;
	logic signed [17:0] hs_q;
	logic signed [39:0] mx_q;
	logic signed [39:0] my_q;
	logic signed [39:0] mz_q;
	logic signed [63:0] acc_q;
	logic signed [56:0] prod_q;
	logic signed [POS_W-1:0] res_px_q, res_py_q, res_pz_q;
	logic signed [POS_W-1:0] res_vx_q, res_vy_q, res_vz_q;
	logic [M_DATA_W-1:0] out_q;

	logic        s_accept;
	logic        out_free;
	logic        foot_in;
	logic        contact_in;
	logic        resync_in;
	logic [15:0] phase_in;
	logic signed [POS_W-1:0] meas_in [3];
	logic signed [POS_W-1:0] tgt_x_in;
	logic signed [POS_W-1:0] tgt_y_in;
	logic        valid_eff;
	logic signed [POS_W-1:0] st_new [3];
	logic [NUM_FEET-1:0] foot_oh;

	logic [IDX_W-1:0] idx;
	logic [1:0]  quad_s;
	logic [1:0]  quad_c;
	logic [R_W-1:0] rem;
	logic [R_W:0] addr_s;
	logic [R_W:0] addr_c;
	logic [ROM_W-1:0] mag_s;
	logic [ROM_W-1:0] mag_c;
	logic signed [17:0] s_val;
	logic signed [17:0] c_val;
	logic signed [18:0] omc_val;

	logic signed [31:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [56:0] mul_p;
	logic [3:0]  cons_op;
	logic signed [63:0] rnd_in;
	logic [5:0]  rnd_sh;
	logic signed [63:0] rnd_out;
	logic signed [POS_W-1:0] st_sel;
	logic signed [POS_W-1:0] sat_out;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;
	assign out_free  = !m_tvalid_q || m_tready;

	assign foot_in    = s_tuser[0];
	assign contact_in = s_tuser[1];
	assign resync_in  = s_tuser[2];
	assign phase_in   = s_tdata[15:0];
	assign meas_in[0] = s_tdata[35:16];
	assign meas_in[1] = s_tdata[55:36];
	assign meas_in[2] = s_tdata[75:56];
	assign tgt_x_in   = s_tdata[95:76];
	assign tgt_y_in   = s_tdata[115:96];
	assign foot_oh    = NUM_FEET'(1) << foot_in;

	// start latch: first word, resync, or early stance re-latches from measurement
	always_comb begin
		valid_eff = !resync_in && valid_q[foot_in];
		for (int a = 0; a < 3; a++) begin
			st_new[a] = (valid_eff && !(contact_in && !phase_in[15])) ?
				start_q[foot_in][a] : meas_in[a];
		end
	end

	// quarter-wave sine and cosine lookup
	always_comb begin
		idx    = phase_q[15 -: IDX_W];
		quad_s = idx[IDX_W-1 -: 2];
		quad_c = quad_s + 2'd1;
		rem    = idx[R_W-1:0];
		addr_s = quad_s[0] ? ((R_W+1)'(SINE_TABLE_DEPTH) - {1'b0, rem}) : {1'b0, rem};
		addr_c = quad_c[0] ? ((R_W+1)'(SINE_TABLE_DEPTH) - {1'b0, rem}) : {1'b0, rem};
		mag_s  = SINE_ROM[addr_s];
		mag_c  = SINE_ROM[addr_c];
		s_val  = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
		c_val  = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		omc_val = 19'(ONE_Q16) - 19'(c_val);
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			OP_SK: begin
				mul_a = 32'(INV_TWO_PI_Q32);
				mul_b = 25'(s_q);
			end
			OP_HS: begin
				mul_a = {16'd0, gait_height_q};
				mul_b = 25'(s_q);
			end
			OP_HZ: begin
				mul_a = {16'd0, gait_height_q};
				mul_b = {7'd0, omc_q};
			end
			OP_MX: begin
				mul_a = 32'(dx_q);
				mul_b = {7'd0, omc_q};
			end
			OP_MY: begin
				mul_a = 32'(dy_q);
				mul_b = {7'd0, omc_q};
			end
			OP_PX: begin
				mul_a = 32'(dx_q);
				mul_b = 25'(f_q);
			end
			OP_PY: begin
				mul_a = 32'(dy_q);
				mul_b = 25'(f_q);
			end
			OP_NZ: begin
				mul_a = 32'(PI_Q16);
				mul_b = 25'(hs_q);
			end
			OP_VX_HI: begin
				mul_a = 32'($signed(mx_q[39:20]));
				mul_b = {1'b0, inv_swing_time_q};
			end
			OP_VX_LO: begin
				mul_a = {12'd0, mx_q[19:0]};
				mul_b = {1'b0, inv_swing_time_q};
			end
			OP_VY_HI: begin
				mul_a = 32'($signed(my_q[39:20]));
				mul_b = {1'b0, inv_swing_time_q};
			end
			OP_VY_LO: begin
				mul_a = {12'd0, my_q[19:0]};
				mul_b = {1'b0, inv_swing_time_q};
			end
			OP_VZ_HI: begin
				mul_a = 32'($signed(mz_q[39:20]));
				mul_b = {1'b0, inv_swing_time_q};
			end
			OP_VZ_LO: begin
				mul_a = {12'd0, mz_q[19:0]};
				mul_b = {1'b0, inv_swing_time_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 57'(mul_a) * 57'(mul_b);

	// rounding and saturation of the product issued one step earlier
	assign cons_op = step_q - 4'd1;

	always_comb begin
		rnd_in = 64'(prod_q);
		rnd_sh = 6'd16;
		st_sel = '0;
		case (cons_op)
			OP_SK: begin
				rnd_sh = 6'd32;
			end
			OP_HZ: begin
				rnd_sh = 6'd17;
				st_sel = start_q[foot_q][2];
			end
			OP_PX: begin
				st_sel = start_q[foot_q][0];
			end
			OP_PY: begin
				st_sel = start_q[foot_q][1];
			end
			OP_VX_LO, OP_VY_LO, OP_VZ_LO: begin
				rnd_in = acc_q + 64'(prod_q);
				rnd_sh = 6'd32;
			end
			default: begin
				rnd_sh = 6'd16;
			end
		endcase
		rnd_out = round_shift(rnd_in, rnd_sh);
		sat_out = sat20(rnd_out + 64'(st_sel));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			step_q           <= '0;
			valid_q          <= '0;
			m_tvalid_q       <= 1'b0;
			gait_height_q    <= GAIT_HEIGHT_RST;
			inv_swing_time_q <= INV_SWING_TIME_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIT_HEIGHT:    gait_height_q    <= cfg_data[15:0];
					REG_INV_SWING_TIME: inv_swing_time_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						valid_q <= resync_in ? foot_oh : (valid_q | foot_oh);
						state_q <= contact_in ? ST_DONE : ST_TRIG;
					end
				end
				ST_TRIG: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == STEP_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			for (int a = 0; a < 3; a++) begin
				start_q[foot_in][a] <= st_new[a];
			end
			foot_q   <= foot_in;
			phase_q  <= phase_in;
			tgt_x_q  <= tgt_x_in;
			tgt_y_q  <= tgt_y_in;
			res_px_q <= st_new[0];
			res_py_q <= st_new[1];
			res_pz_q <= st_new[2];
			res_vx_q <= '0;
			res_vy_q <= '0;
			res_vz_q <= '0;
		end
		if (state_q == ST_TRIG) begin
			s_q   <= s_val;
			omc_q <= omc_val[17:0];
			dx_q  <= 21'(tgt_x_q) - 21'(start_q[foot_q][0]);
			dy_q  <= 21'(tgt_y_q) - 21'(start_q[foot_q][1]);
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_p;
			case (cons_op)
				OP_SK:    f_q  <= $signed({2'b00, phase_q}) - 18'(rnd_out);
				OP_HS:    hs_q <= 18'(rnd_out);
				OP_HZ:    res_pz_q <= sat_out;
				OP_MX:    mx_q <= 40'(prod_q);
				OP_MY:    my_q <= 40'(prod_q);
				OP_PX:    res_px_q <= sat_out;
				OP_PY:    res_py_q <= sat_out;
				OP_NZ:    mz_q <= 40'(prod_q);
				OP_VX_HI, OP_VY_HI, OP_VZ_HI: acc_q <= 64'(prod_q) <<< 20;
				OP_VX_LO: res_vx_q <= sat_out;
				OP_VY_LO: res_vy_q <= sat_out;
				OP_VZ_LO: res_vz_q <= sat_out;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= {res_vz_q, res_vy_q, res_vx_q, res_pz_q, res_py_q, res_px_q};
		end
	end

	`CSFT_ASSERT_NEXT(a_swing_starts_trig, clk, arst_n, s_accept && !contact_in, state_q == ST_TRIG, "swing word did not start the sine lookup")
	`CSFT_ASSERT_NEXT(a_start_valid_set, clk, arst_n, s_accept, valid_q[$past(foot_in)], "start not marked valid after a word")
	`CSFT_ASSERT_IMPL(a_step_range, clk, arst_n, state_q == ST_MUL, step_q <= STEP_LAST, "sequencer step out of range")
	`CSFT_ASSERT_NEXT(a_done_delivers, clk, arst_n, state_q == ST_DONE && out_free, m_tvalid_q && state_q == ST_IDLE, "finished word not presented")

endmodule

@@ dv/tb_cycloid_swing_foot_trajectory.sv @@
// Self-checking bench for cycloid_swing_foot_trajectory: stance/swing word streams,
// register rewrites between phases, a scoreboard that predicts every setpoint word.
// Depends on csft_pkg and the block RTL only.
`timescale 1ns / 1ps

module tb_cycloid_swing_foot_trajectory;

	import csft_pkg::*;

	localparam int TBL            = SINE_TABLE_DEPTH;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 24;

	typedef struct packed {
		logic               foot;
		logic               contact;
		logic               resync;
		logic [15:0]        phase;
		logic signed [19:0] mx;
		logic signed [19:0] my;
		logic signed [19:0] mz;
		logic signed [19:0] tx;
		logic signed [19:0] ty;
	} step_t;

	class foot_traj_board;
		longint      anchor [NUM_FEET][3];
		bit          anchor_ok [NUM_FEET];
		longint      lift;
		longint      rate;
		longint      quarter_sine [TBL+1];
		logic [119:0] setpoint_q [$];
		string       field_name [6];
		int          errors;

		function new();
			bit [63:0] x;
			bit [63:0] x2;
			bit [63:0] term;
			longint    sum;
			lift   = 5243;
			rate   = 163840;
			errors = 0;
			field_name = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
			for (int f = 0; f < NUM_FEET; f++) begin
				anchor_ok[f] = 1'b0;
				for (int a = 0; a < 3; a++) begin
					anchor[f][a] = 0;
				end
			end
			// quarter-wave sine, Q30 Taylor series rounded to Q16
			for (int k = 0; k <= TBL; k++) begin
				x    = (64'd1686629713 * 64'(k)) / 64'(TBL);
				x2   = (x * x) >> 30;
				term = x;
				sum  = longint'(x);
				for (int n = 1; n <= 8; n++) begin
					term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						sum = sum - longint'(term);
					end else begin
						sum = sum + longint'(term);
					end
				end
				if (sum < 0) begin
					sum = 0;
				end
				sum = (sum + 8192) >>> 14;
				if (sum > 65536) begin
					sum = 65536;
				end
				quarter_sine[k] = sum;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [23:0] value);
			case (index)
				REG_GAIT_HEIGHT: begin
					lift = longint'(value[15:0]);
				end
				REG_INV_SWING_TIME: begin
					rate = longint'(value);
				end
				default: begin
				end
			endcase
		endfunction

		function longint sine_of(int unsigned ix);
			int unsigned q;
			int unsigned r;
			longint      v;
			q = (ix / TBL) % 4;
			r = ix % TBL;
			v = (q % 2 == 1) ? quarter_sine[TBL - r] : quarter_sine[r];
			return (q >= 2) ? -v : v;
		endfunction

		function longint round_off(longint v, int sh);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (longint'(1) << (sh - 1))) >>> sh;
			return (v < 0) ? -m : m;
		endfunction

		function logic [19:0] clip(longint v);
			if (v > 524287) begin
				return 20'h7FFFF;
			end else if (v < -524288) begin
				return 20'h80000;
			end
			return 20'(v);
		endfunction

		function logic [119:0] predict_setpoint(step_t it);
			longint       mv [3];
			longint       tv [2];
			longint       res_pos [3];
			longint       res_vel [3];
			longint       s;
			longint       c;
			longint       omc;
			longint       fr;
			longint       d;
			longint       hs;
			int unsigned  ix;
			int           ft;
			logic [119:0] word;
			mv[0] = longint'($signed(it.mx));
			mv[1] = longint'($signed(it.my));
			mv[2] = longint'($signed(it.mz));
			tv[0] = longint'($signed(it.tx));
			tv[1] = longint'($signed(it.ty));
			ft    = int'(it.foot);
			if (it.resync) begin
				for (int f = 0; f < NUM_FEET; f++) begin
					anchor_ok[f] = 1'b0;
				end
			end
			for (int a = 0; a < 3; a++) begin
				res_pos[a] = 0;
				res_vel[a] = 0;
			end
			if (ft < NUM_FEET) begin
				if (!anchor_ok[ft]) begin
					for (int a = 0; a < 3; a++) begin
						anchor[ft][a] = mv[a];
					end
					anchor_ok[ft] = 1'b1;
				end
				if (it.contact) begin
					if (it.phase < 16'd32768) begin
						for (int a = 0; a < 3; a++) begin
							anchor[ft][a] = mv[a];
						end
					end
					for (int a = 0; a < 3; a++) begin
						res_pos[a] = anchor[ft][a];
					end
				end else begin
					ix  = (int'(it.phase) * 4 * TBL) >> 16;
					s   = sine_of(ix);
					c   = sine_of((ix + TBL) % (4 * TBL));
					omc = 65536 - c;
					fr  = longint'(it.phase) - round_off(s * 683565276, 32);
					for (int a = 0; a < 2; a++) begin
						d          = tv[a] - anchor[ft][a];
						res_pos[a] = anchor[ft][a] + round_off(d * fr, 16);
						res_vel[a] = round_off(d * omc * rate, 32);
					end
					res_pos[2] = anchor[ft][2] + round_off(lift * omc, 17);
					hs         = round_off(lift * s, 16);
					res_vel[2] = round_off(hs * 205887 * rate, 32);
				end
			end
			for (int a = 0; a < 3; a++) begin
				word[a*20 +: 20]       = clip(res_pos[a]);
				word[(a+3)*20 +: 20]   = clip(res_vel[a]);
			end
			return word;
		endfunction

		function void note_step(step_t it);
			setpoint_q.push_back(predict_setpoint(it));
		endfunction

		function void check_setpoint(logic [119:0] got);
			logic [119:0] want;
			if (setpoint_q.size() == 0) begin
				$error("setpoint word with none pending: %h", got);
				errors++;
				return;
			end
			want = setpoint_q.pop_front();
			for (int k = 0; k < 6; k++) begin
				if (got[k*20 +: 20] !== want[k*20 +: 20]) begin
					$error("%s: expected %0d, got %0d", field_name[k],
						$signed(want[k*20 +: 20]), $signed(got[k*20 +: 20]));
					errors++;
				end
			end
		endfunction

		function int pending();
			return setpoint_q.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic [S_USER_W-1:0]   s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;

	foot_traj_board board = new();
	bit             idle_on = 1'b1;
	int             quiet = 0;

	cycloid_swing_foot_trajectory DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_setpoint(m_tdata);
		end
	end

	// sink side back-pressure
	initial begin
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (idle_on && $urandom_range(0, 1) == 1) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	initial begin
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAIL");
		$finish;
	end

	function automatic step_t mk_step(logic ft, logic ct, logic rs, logic [15:0] ph,
			logic [19:0] mx, logic [19:0] my, logic [19:0] mz,
			logic [19:0] tx, logic [19:0] ty);
		step_t it;
		it.foot    = ft;
		it.contact = ct;
		it.resync  = rs;
		it.phase   = ph;
		it.mx      = mx;
		it.my      = my;
		it.mz      = mz;
		it.tx      = tx;
		it.ty      = ty;
		return it;
	endfunction

	function automatic logic [19:0] pick_pos(bit wide);
		if (wide) begin
			return 20'($urandom);
		end
		return 20'(int'($urandom_range(0, 131071)) - 65536);
	endfunction

	function automatic logic [19:0] jitter(logic [19:0] v);
		return v + 20'(int'($urandom_range(0, 2047)) - 1024);
	endfunction

	task automatic send_step(input step_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tdata  <= {4'b0, it.ty, it.tx, it.mz, it.my, it.mx, it.phase};
		s_tuser  <= {it.resync, it.contact, it.foot};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_step(it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] gh, input logic [23:0] ist);
		cfg_index <= REG_GAIT_HEIGHT;
		cfg_data  <= 24'(gh);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(REG_GAIT_HEIGHT, 24'(gh));
		cfg_index <= REG_INV_SWING_TIME;
		cfg_data  <= ist;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(REG_INV_SWING_TIME, ist);
		cfg_valid <= 1'b0;
	endtask

	// mostly whole stance-then-swing strides, some arbitrary words
	task automatic run_strides(input int count);
		int          sent;
		int          n;
		bit          wide;
		logic        ft;
		logic [19:0] bx;
		logic [19:0] by;
		logic [19:0] bz;
		logic [19:0] gx;
		logic [19:0] gy;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 8) begin
				ft   = 1'($urandom_range(0, 1));
				wide = ($urandom_range(0, 3) == 0);
				bx   = pick_pos(wide);
				by   = pick_pos(wide);
				bz   = pick_pos(wide);
				gx   = pick_pos(wide);
				gy   = pick_pos(wide);
				n    = $urandom_range(2, 8);
				for (int j = 0; j < n; j++) begin
					send_step(mk_step(ft, 1'b1, (j == 0) && ($urandom_range(0, 7) == 0),
						16'((j * 65536) / n + $urandom_range(0, 255)),
						jitter(bx), jitter(by), jitter(bz), gx, gy));
				end
				sent += n;
				n = $urandom_range(2, 10);
				for (int j = 0; j < n; j++) begin
					send_step(mk_step(ft, 1'b0, 1'b0, 16'((j * 65535) / (n - 1)),
						jitter(bx), jitter(by), jitter(bz), gx, gy));
				end
				sent += n;
			end else begin
				send_step(mk_step(1'($urandom), 1'($urandom), ($urandom_range(0, 3) == 0),
					16'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
					20'($urandom), 20'($urandom)));
				sent++;
			end
		end
	endtask

	localparam logic [19:0] QMAX = 20'h7FFFF;
	localparam logic [19:0] QMIN = 20'h80000;

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words under reset register values
		send_step(mk_step(1'b0, 1'b0, 1'b0, 16'd16384, 20'd1000, -20'sd2000, 20'd300,
			20'd30000, -20'sd40000));
		send_step(mk_step(1'b1, 1'b1, 1'b0, 16'd0, QMIN, QMAX, QMIN, QMAX, QMIN));
		send_step(mk_step(1'b1, 1'b1, 1'b0, 16'd32767, QMAX, QMIN, QMAX, QMIN, QMAX));
		send_step(mk_step(1'b1, 1'b1, 1'b0, 16'd32768, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0));
		send_step(mk_step(1'b1, 1'b1, 1'b0, 16'd65535, 20'd777, 20'd888, 20'd999,
			20'd1, 20'd2));
		send_step(mk_step(1'b1, 1'b0, 1'b0, 16'd0, 20'd5, 20'd6, 20'd7, QMIN, QMAX));
		send_step(mk_step(1'b1, 1'b0, 1'b0, 16'd32768, 20'd5, 20'd6, 20'd7, QMIN, QMAX));
		send_step(mk_step(1'b1, 1'b0, 1'b0, 16'd49152, 20'd5, 20'd6, 20'd7, QMIN, QMAX));
		send_step(mk_step(1'b1, 1'b0, 1'b0, 16'd65535, 20'd5, 20'd6, 20'd7, QMIN, QMAX));
		send_step(mk_step(1'b0, 1'b0, 1'b0, 16'd0, 20'd0, 20'd0, 20'd0, QMAX, QMIN));
		send_step(mk_step(1'b0, 1'b0, 1'b0, 16'd65535, 20'd0, 20'd0, 20'd0, QMAX, QMIN));
		send_step(mk_step(1'b0, 1'b1, 1'b1, 16'd40000, 20'd12345, -20'sd23456, 20'd3456,
			20'd0, 20'd0));
		send_step(mk_step(1'b1, 1'b0, 1'b0, 16'd20000, QMIN, QMIN, QMIN, QMAX, QMAX));
		send_step(mk_step(1'b1, 1'b1, 1'b0, 16'd65535, QMAX, QMAX, QMAX, QMIN, QMIN));
		send_step(mk_step(1'b1, 1'b0, 1'b1, 16'd65535, QMAX, QMAX, QMAX, QMIN, QMIN));
		send_step(mk_step(1'b0, 1'b0, 1'b0, 16'd8192, 20'd0, 20'd0, 20'd0, 20'd65536,
			-20'sd65536));
		drain();

		program_regs(16'hFFFF, 24'hFFFFFF);
		send_step(mk_step(1'b1, 1'b0, 1'b1, 16'd16384, QMAX, QMIN, QMAX, QMIN, QMAX));
		send_step(mk_step(1'b1, 1'b0, 1'b0, 16'd49152, QMAX, QMIN, QMAX, QMIN, QMAX));
		run_strides(220);
		drain();

		program_regs(16'd0, 24'd1);
		run_strides(220);
		drain();

		// zero swing rate
		program_regs(16'($urandom), 24'd0);
		run_strides(220);
		drain();

		program_regs(16'($urandom), 24'($urandom));
		run_strides(220);
		drain();

		program_regs(16'd5243, 24'd163840);
		run_strides(220);
		drain();

		idle_on = 1'b0;
		program_regs(16'($urandom), 24'($urandom_range(1, 1048576)));
		run_strides(220);
		drain();

		if (board.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
